// ===== src/sbsh_pkg.sv =====
`timescale 1ns / 1ps

package sbsh_pkg;

   typedef logic [31:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_LEN,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_PAD,
      KIND_LAST
   } kind_type;

   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned HASH_WORDS  = 8;
   localparam logic [5:0]  LAST_ROUND  = 6'd63;
   localparam logic [5:0]  LAST_BYTE   = 6'd63;
   localparam logic [5:0]  LEN_LIMIT   = 6'd56;
   localparam logic [7:0]  PAD_BYTE    = 8'h80;

   localparam word_type ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type INITIAL_HASH [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

// ===== src/sbsh_if.sv =====
`timescale 1ns / 1ps

interface sbsh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source(output valid, data_byte, has_byte, end_of_message, input ready);
   modport sink(input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sbsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        final_word;
   logic        length_error;

   modport source(output valid, digest_word, word_number, final_word, length_error,
                  input ready);
   modport sink(input valid, digest_word, word_number, final_word, length_error,
                output ready);
endinterface

// ===== src/sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps

// SHA-256 hasher that takes one message byte per transfer and returns the digest as eight
// 32-bit words, most significant first. The transfer that completes a 64-byte block is
// followed by a busy compression (64 rounds through the single round unit, then the hash
// update). Closing a message without a length error runs a padding step and one or two
// such compressions (the second one preceded by a step that builds the length block),
// after which the eight digest words are offered one per cycle while rsp_chan.ready is
// high. The input is not ready while a compression runs or the digest is being delivered.
// A message longer than 2^61-1 bytes yields an all-zero digest with length_error set.
module sha256_byte_stream_hasher
   import sbsh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sbsh_req_if.sink   req_chan,
   sbsh_rsp_if.source rsp_chan
);

   state_type   state_ff, state_in;
   kind_type    kind_ff, kind_in;
   logic        close_ff, close_in;
   logic        ovf_ff, ovf_in;
   logic [5:0]  round_ff, round_in;
   logic [5:0]  pos_ff, pos_in;
   logic [2:0]  out_cnt_ff, out_cnt_in;
   logic [60:0] msg_ff, msg_in;
   word_type    hash_ff [HASH_WORDS];
   word_type    hash_in [HASH_WORDS];
   word_type    work_ff [HASH_WORDS];
   word_type    work_in [HASH_WORDS];
   word_type    blk_ff  [BLOCK_WORDS];
   word_type    blk_in  [BLOCK_WORDS];

   word_type    t1, t2, sched_new;
   logic [63:0] bit_len;

   assign t1 = work_ff[7] + big_sigma1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + ROUND_K[round_ff] + blk_ff[0];
   assign t2 = big_sigma0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));
   assign sched_new = blk_ff[0] + small_sigma0(blk_ff[1]) + blk_ff[9]
                    + small_sigma1(blk_ff[14]);
   assign bit_len = {msg_ff, 3'b000};

   always_comb begin
      logic       put;
      logic       zero_above;
      logic       clear_all;
      logic       put_len;
      logic       start;
      logic [7:0] byte_val;
      logic [3:0] idx;
      logic [5:0] pos_next;
      word_type   ins_word;

      state_in   = state_ff;
      kind_in    = kind_ff;
      close_in   = close_ff;
      ovf_in     = ovf_ff;
      round_in   = round_ff;
      pos_in     = pos_ff;
      out_cnt_in = out_cnt_ff;
      msg_in     = msg_ff;
      hash_in    = hash_ff;
      work_in    = work_ff;
      blk_in     = blk_ff;

      put        = 1'b0;
      zero_above = 1'b0;
      clear_all  = 1'b0;
      put_len    = 1'b0;
      start      = 1'b0;
      byte_val   = PAD_BYTE;
      idx        = pos_ff[5:2];
      pos_next   = pos_ff + 6'd1;

      req_chan.ready        = 1'b0;
      rsp_chan.valid        = 1'b0;
      rsp_chan.digest_word  = ovf_ff ? 32'd0 : hash_ff[out_cnt_ff];
      rsp_chan.word_number  = out_cnt_ff;
      rsp_chan.final_word   = (out_cnt_ff == 3'd7);
      rsp_chan.length_error = ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               close_in = req_chan.end_of_message;
               if (req_chan.has_byte && !ovf_ff) begin
                  if (&msg_ff) begin
                     ovf_in = 1'b1;
                  end else begin
                     msg_in   = msg_ff + 61'd1;
                     put      = 1'b1;
                     byte_val = req_chan.data_byte;
                  end
               end
               if (put && pos_ff == LAST_BYTE) begin
                  start   = 1'b1;
                  kind_in = KIND_DATA;
               end else if (req_chan.end_of_message) begin
                  state_in = ovf_in ? ST_OUT : ST_PAD;
               end
            end
         end
         ST_PAD: begin
            put        = 1'b1;
            zero_above = 1'b1;
            start      = 1'b1;
            if (pos_next == 6'd0 || pos_next > LEN_LIMIT) begin
               kind_in = KIND_PAD;
            end else begin
               put_len = 1'b1;
               kind_in = KIND_LAST;
            end
         end
         ST_LEN: begin
            clear_all = 1'b1;
            put_len   = 1'b1;
            start     = 1'b1;
            kind_in   = KIND_LAST;
         end
         ST_ROUND: begin
            work_in[0] = t1 + t2;
            work_in[1] = work_ff[0];
            work_in[2] = work_ff[1];
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3] + t1;
            work_in[5] = work_ff[4];
            work_in[6] = work_ff[5];
            work_in[7] = work_ff[6];
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
               blk_in[i] = blk_ff[i + 1];
            end
            blk_in[BLOCK_WORDS - 1] = sched_new;
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < HASH_WORDS; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
            case (kind_ff)
               KIND_DATA: state_in = close_ff ? ST_PAD : ST_IDLE;
               KIND_PAD:  state_in = ST_LEN;
               KIND_LAST: state_in = ST_OUT;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_OUT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               out_cnt_in = out_cnt_ff + 3'd1;
               if (out_cnt_ff == 3'd7) begin
                  state_in = ST_IDLE;
                  close_in = 1'b0;
                  ovf_in   = 1'b0;
                  pos_in   = 6'd0;
                  msg_in   = '0;
                  for (int i = 0; i < HASH_WORDS; i++) begin
                     hash_in[i] = INITIAL_HASH[i];
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Byte insertion, big-endian within each word.
      ins_word = ((pos_ff[1:0] == 2'd0) ? 32'd0 : blk_ff[idx])
               | ({24'd0, byte_val} << {~pos_ff[1:0], 3'b000});
      if (put) begin
         blk_in[idx] = ins_word;
         pos_in      = pos_next;
      end
      if (zero_above) begin
         for (int i = 0; i < BLOCK_WORDS; i++) begin
            if (4'(i) > idx) begin
               blk_in[i] = 32'd0;
            end
         end
      end
      if (clear_all) begin
         for (int i = 0; i < BLOCK_WORDS; i++) begin
            blk_in[i] = 32'd0;
         end
      end
      if (put_len) begin
         blk_in[BLOCK_WORDS - 2] = bit_len[63:32];
         blk_in[BLOCK_WORDS - 1] = bit_len[31:0];
      end
      if (start) begin
         state_in = ST_ROUND;
         round_in = 6'd0;
         work_in  = hash_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         kind_ff    <= KIND_DATA;
         close_ff   <= 1'b0;
         ovf_ff     <= 1'b0;
         round_ff   <= 6'd0;
         pos_ff     <= 6'd0;
         out_cnt_ff <= 3'd0;
         msg_ff     <= '0;
         for (int i = 0; i < HASH_WORDS; i++) begin
            hash_ff[i] <= INITIAL_HASH[i];
         end
      end else begin
         state_ff   <= state_in;
         kind_ff    <= kind_in;
         close_ff   <= close_in;
         ovf_ff     <= ovf_in;
         round_ff   <= round_in;
         pos_ff     <= pos_in;
         out_cnt_ff <= out_cnt_in;
         msg_ff     <= msg_in;
         hash_ff    <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      blk_ff  <= blk_in;
   end

endmodule

// ===== tb/sv/tb_sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps

import sbsh_pkg::*;

typedef struct packed {
   word_type   digest_word;
   logic [2:0] word_number;
   logic       final_word;
   logic       length_error;
} digest_result_type;

class digest_scoreboard;
   word_type          round_const [64];
   word_type          start_hash [8];
   word_type          chain [8];
   word_type          block_words [16];
   logic [5:0]        fill_count;
   logic [61:0]       bytes_taken;
   logic              overflowed;
   digest_result_type awaited [$];
   int                failures;

   function new();
      round_const = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
         32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
         32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
         32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
         32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
         32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
         32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
         32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
         32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
         32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
         32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
      };
      start_hash = '{
         32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
         32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
      };
      failures = 0;
      restart();
   endfunction

   function void restart();
      chain = start_hash;
      foreach (block_words[i]) block_words[i] = '0;
      fill_count = '0;
      bytes_taken = '0;
      overflowed = 1'b0;
   endfunction

   function word_type rot_right(word_type v, int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function void compress();
      word_type sched [16];
      word_type s [8];
      word_type w;
      word_type x;
      word_type y;
      word_type t1;
      word_type t2;
      int       r;
      sched = block_words;
      s = chain;
      for (r = 0; r < 64; r++) begin
         if (r < 16) begin
            w = sched[r];
         end else begin
            x = sched[(r - 15) & 15];
            y = sched[(r - 2) & 15];
            w = sched[r & 15] + (rot_right(x, 7) ^ rot_right(x, 18) ^ (x >> 3))
              + sched[(r - 7) & 15] + (rot_right(y, 17) ^ rot_right(y, 19) ^ (y >> 10));
            sched[r & 15] = w;
         end
         t1 = s[7] + (rot_right(s[4], 6) ^ rot_right(s[4], 11) ^ rot_right(s[4], 25))
            + ((s[4] & s[5]) ^ (~s[4] & s[6])) + round_const[r] + w;
         t2 = (rot_right(s[0], 2) ^ rot_right(s[0], 13) ^ rot_right(s[0], 22))
            + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
         s[7] = s[6];
         s[6] = s[5];
         s[5] = s[4];
         s[4] = s[3] + t1;
         s[3] = s[2];
         s[2] = s[1];
         s[1] = s[0];
         s[0] = t1 + t2;
      end
      foreach (chain[i]) chain[i] = chain[i] + s[i];
   endfunction

   function void take_byte(logic [7:0] b);
      int idx;
      int shift_amt;
      idx = int'(fill_count[5:2]);
      shift_amt = (3 - int'(fill_count[1:0])) * 8;
      if (fill_count[1:0] == 2'd0) begin
         block_words[idx] = '0;
      end
      block_words[idx] = block_words[idx] | (word_type'(b) << shift_amt);
      fill_count = fill_count + 6'd1;
      if (fill_count == 6'd0) begin
         compress();
      end
   endfunction

   function void close_message();
      logic [63:0] length_bits;
      int          i;
      length_bits = {bytes_taken[60:0], 3'b000};
      take_byte(8'h80);
      for (i = (int'(fill_count) + 3) >> 2; i < 16; i++) block_words[i] = '0;
      if (fill_count > 6'd56 || fill_count == 6'd0) begin
         if (fill_count != 6'd0) begin
            compress();
         end
         foreach (block_words[j]) block_words[j] = '0;
      end
      block_words[14] = length_bits[63:32];
      block_words[15] = length_bits[31:0];
      compress();
   endfunction

   function void note_item(logic [7:0] data_byte, logic has_byte, logic end_of_message);
      digest_result_type r;
      int                k;
      if (has_byte && !overflowed) begin
         if (bytes_taken >= 62'h1FFF_FFFF_FFFF_FFFF) begin
            overflowed = 1'b1;
         end else begin
            bytes_taken = bytes_taken + 62'd1;
            take_byte(data_byte);
         end
      end
      if (!end_of_message) begin
         return;
      end
      if (!overflowed) begin
         close_message();
      end
      for (k = 0; k < 8; k++) begin
         r.digest_word = overflowed ? '0 : chain[k];
         r.word_number = 3'(k);
         r.final_word = (k == 7);
         r.length_error = overflowed;
         awaited.push_back(r);
      end
      restart();
   endfunction

   function void check_word(digest_result_type got);
      digest_result_type want;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected digest word: expected none, actual %h",
                  $time, got.digest_word);
         failures++;
         return;
      end
      want = awaited.pop_front();
      if (got.digest_word !== want.digest_word) begin
         $display("%0t: digest_word: expected %h, actual %h",
                  $time, want.digest_word, got.digest_word);
         failures++;
      end
      if (got.word_number !== want.word_number) begin
         $display("%0t: word_number: expected %0d, actual %0d",
                  $time, want.word_number, got.word_number);
         failures++;
      end
      if (got.final_word !== want.final_word) begin
         $display("%0t: final_word: expected %b, actual %b",
                  $time, want.final_word, got.final_word);
         failures++;
      end
      if (got.length_error !== want.length_error) begin
         $display("%0t: length_error: expected %b, actual %b",
                  $time, want.length_error, got.length_error);
         failures++;
      end
   endfunction

   function int pending();
      return awaited.size();
   endfunction
endclass

module tb_sha256_byte_stream_hasher;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned ITEM_TARGET  = 410;
   localparam int unsigned DRAIN_CYCLES = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   bit          req_burst = 1'b0;
   bit          rsp_burst = 1'b0;

   digest_scoreboard scoreboard = new();

   sbsh_req_if req_bus();
   sbsh_rsp_if rsp_bus();

   sha256_byte_stream_hasher dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic [7:0] data, input logic has, input logic last);
      int unsigned gap;
      if ($urandom_range(0, 31) == 0) begin
         req_burst = !req_burst;
      end
      gap = req_burst ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      repeat (gap) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.data_byte = data;
      req_bus.has_byte = has;
      req_bus.end_of_message = last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      scoreboard.note_item(data, has, last);
      if (has || last) begin
         items_sent++;
      end
   endtask

   task automatic send_message(input int unsigned len);
      bit          close_on_byte;
      int unsigned i;
      close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         send_item(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (i == len - 1));
      end
      if (!close_on_byte) begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
   endtask

   function automatic int unsigned pick_length();
      int unsigned boundary_len [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(0, 6);
         6, 7: return boundary_len[$urandom_range(0, 7)];
         8: return $urandom_range(7, 70);
         default: return $urandom_range(0, 130);
      endcase
   endfunction

   task automatic run_directed();
      // An empty message, then an ignored item followed by another empty message.
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h80, 1'b1, 1'b1);
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.has_byte = 1'b0;
      req_bus.end_of_message = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      while (items_sent < ITEM_TARGET) send_message(pick_length());
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      int unsigned       stall;
      digest_result_type got;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) begin
            rsp_burst = !rsp_burst;
         end
         stall = rsp_burst ? 0 : $urandom_range(0, 15);
         repeat (stall) begin
            rsp_bus.ready = 1'b0;
            @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         got.digest_word = rsp_bus.digest_word;
         got.word_number = rsp_bus.word_number;
         got.final_word = rsp_bus.final_word;
         got.length_error = rsp_bus.length_error;
         scoreboard.check_word(got);
         @(negedge clock);
      end
   end

endmodule

// ===== files.f =====
src/sbsh_pkg.sv
src/sbsh_if.sv
src/sha256_byte_stream_hasher.sv
tb/sv/tb_sha256_byte_stream_hasher.sv
